>>> rtl/phf_pkg.sv
// Shared types and constants for the per-pad ADC histogram fill block.
// Used by phf_ctrl, phf_datapath and per_pad_adc_histogram_fill_core.
`default_nettype none

package phf_pkg;

    localparam int CTR_W    = 32;
    localparam int ADC_W    = 10;
    localparam int DET_IN_W = 2;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 8;
    localparam int ROWS_W   = 5;
    localparam int RSLOT_W  = 5;
    localparam int PADF_W   = 13;
    localparam int SLOTF_W  = 11;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    localparam logic REG_ADC_LOW  = 1'b0;
    localparam logic REG_ADC_HIGH = 1'b1;

    localparam logic [ADC_W-1:0] ADC_LOW_RESET  = 10'd0;
    localparam logic [ADC_W-1:0] ADC_HIGH_RESET = 10'd20;

    localparam logic [CTR_W-1:0] CTR_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clear;
        logic capture;
        logic calc;
        logic addr;
        logic rd;
        logic upd;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_stall;
    } t_ctl_sts;

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        return (v == CTR_MAX) ? v : v + CTR_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/phf_ctrl.sv
// Controller state machine: memory clear sweep, then one item through
// calc, address, read and update steps. Depends on phf_pkg.
`default_nettype none

module phf_ctrl
    import phf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_READ,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (!i_sts.out_stall) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/phf_datapath.sv
// Datapath: limit registers, pad and slot arithmetic, counter memory,
// discard counters and output register. Depends on phf_pkg.
`default_nettype none

module phf_datapath
    import phf_pkg::*;
#(
    parameter int DETECTORS         = 4,
    parameter int PADS_PER_DETECTOR = 4096,
    parameter int BIN_SLOTS         = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl_cmd             i_cmd,
    output t_ctl_sts                  o_sts,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_s_tuser,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_index,
    input  wire logic [ADC_W-1:0]     i_cfg_data,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic                      o_m_tuser
);

    localparam longint DEPTH  = longint'(DETECTORS) * longint'(PADS_PER_DETECTOR)
                                * longint'(BIN_SLOTS);
    localparam int     ADDR_W = $clog2(DEPTH);
    localparam int     DET_W  = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int     PAD_W  = $clog2(PADS_PER_DETECTOR);
    localparam int     SLOT_W = $clog2(BIN_SLOTS);

    logic [ADC_W-1:0]    r_adc_low;
    logic [ADC_W-1:0]    r_adc_high;

    logic                r_cmd;
    logic [DET_IN_W-1:0] r_det;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ROWS_W-1:0]   r_rows;
    logic [ADC_W-1:0]    r_sample;
    logic [RSLOT_W-1:0]  r_rslot;

    logic [DET_W-1:0]    r_det_idx;
    logic [ADDR_W-1:0]   r_det_base;
    logic [PAD_W-1:0]    r_pad;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_det_ok;
    logic                r_acc_ok;
    logic                r_rd_ok;

    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [CTR_W-1:0]    r_rdata;
    logic [CTR_W-1:0]    r_mem [0:DEPTH-1];
    logic [CTR_W-1:0]    r_disc [DETECTORS];

    logic                r_m_valid;
    logic [CTR_W-1:0]    r_m_value;
    logic [CTR_W-1:0]    r_m_discard;
    logic                r_m_inrange;

    logic [PADF_W-1:0]   pad_full;
    logic [SLOTF_W-1:0]  slot_full;
    logic                in_lim;
    logic                slot_ok;
    logic                rslot_ok;
    logic                pad_ok;
    logic                det_ok;
    logic [CTR_W-1:0]    ctr_inc;
    logic [CTR_W-1:0]    disc_cur;
    logic [CTR_W-1:0]    disc_inc;
    logic                disc_we;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CTR_W-1:0]    mem_wdata;
    logic [CTR_W-1:0]    n_m_value;
    logic [CTR_W-1:0]    n_m_discard;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_low  <= ADC_LOW_RESET;
            r_adc_high <= ADC_HIGH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ADC_LOW:  r_adc_low  <= i_cfg_data;
                REG_ADC_HIGH: r_adc_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_s_tuser;
            r_det    <= i_s_tdata[1:0];
            r_row    <= i_s_tdata[5:2];
            r_col    <= i_s_tdata[13:6];
            r_rows   <= i_s_tdata[18:14];
            r_sample <= i_s_tdata[28:19];
            r_rslot  <= i_s_tdata[33:29];
        end
    end

    always_comb begin
        pad_full  = PADF_W'(r_row) + PADF_W'(r_col) * PADF_W'(r_rows);
        pad_ok    = 32'(pad_full) < 32'(PADS_PER_DETECTOR);
        det_ok    = 32'(r_det) < 32'(DETECTORS);
        in_lim    = (r_sample >= r_adc_low) && (r_sample <= r_adc_high);
        slot_full = SLOTF_W'(r_sample) - SLOTF_W'(r_adc_low) + SLOTF_W'(1);
        slot_ok   = 32'(slot_full) < 32'(BIN_SLOTS);
        rslot_ok  = 32'(r_rslot) < 32'(BIN_SLOTS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_det_idx  <= DET_W'(r_det);
            r_det_base <= ADDR_W'(r_det) * ADDR_W'(PADS_PER_DETECTOR);
            r_pad      <= PAD_W'(pad_full);
            r_slot     <= (r_cmd == CMD_READ) ? SLOT_W'(r_rslot) : SLOT_W'(slot_full);
            r_det_ok   <= det_ok;
            r_acc_ok   <= (r_cmd == CMD_ACCUMULATE) && det_ok && pad_ok && in_lim
                          && slot_ok;
            r_rd_ok    <= (r_cmd == CMD_READ) && det_ok && pad_ok && rslot_ok;
        end
        if (i_cmd.addr) begin
            r_addr <= (r_det_base + ADDR_W'(r_pad)) * ADDR_W'(BIN_SLOTS)
                      + ADDR_W'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_comb begin
        ctr_inc   = sat_inc(r_rdata);
        mem_we    = i_cmd.clear || (i_cmd.upd && r_acc_ok);
        mem_waddr = i_cmd.clear ? r_clr_addr : r_addr;
        mem_wdata = i_cmd.clear ? '0 : ctr_inc;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_comb begin
        disc_cur = r_disc[r_det_idx];
        disc_inc = sat_inc(disc_cur);
        disc_we  = (r_cmd == CMD_ACCUMULATE) && r_det_ok && !r_acc_ok;
        if (r_acc_ok) begin
            n_m_value = ctr_inc;
        end else if (r_rd_ok) begin
            n_m_value = r_rdata;
        end else begin
            n_m_value = '0;
        end
        if (!r_det_ok) begin
            n_m_discard = '0;
        end else if (disc_we) begin
            n_m_discard = disc_inc;
        end else begin
            n_m_discard = disc_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DETECTORS; i++) begin
                r_disc[i] <= '0;
            end
        end else if (i_cmd.upd && disc_we) begin
            r_disc[r_det_idx] <= disc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (i_cmd.upd) begin
            r_m_value   <= n_m_value;
            r_m_discard <= n_m_discard;
            r_m_inrange <= r_acc_ok;
        end
    end

    assign o_sts.clear_done = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.out_stall  = r_m_valid && !i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_discard, r_m_value};
    assign o_m_tuser  = r_m_inrange;

endmodule

`default_nettype wire

>>> rtl/per_pad_adc_histogram_fill_core.sv
// The controller takes each item through the accept, calc, address, memory read and
// update steps, and accepts no new item until the last is through the update step.
// The result register lets the next item be accepted while a result waits.
// Reset (synchronous, active low) clears the discard counters, then sweeps the
// counter memory, one entry a cycle, over all DETECTORS*PADS_PER_DETECTOR*BIN_SLOTS
// entries (524288 at the defaults), with no item accepted; config writes are taken.
`default_nettype none

module per_pad_adc_histogram_fill_core
    import phf_pkg::*;
#(
    parameter int DETECTORS         = 4,
    parameter int PADS_PER_DETECTOR = 4096,
    parameter int BIN_SLOTS         = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // detector_index, pad_row, pad_column, rows_per_chamber, adc_sample, read_slot
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // counter_value, discard_count
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // sample_in_range
    output logic                      m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [ADC_W-1:0]     i_cfg_data
);

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    assign o_cfg_ready = 1'b1;

    phf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    phf_datapath #(
        .DETECTORS         (DETECTORS),
        .PADS_PER_DETECTOR (PADS_PER_DETECTOR),
        .BIN_SLOTS         (BIN_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire
